// ===== src/triangle_list_hit_test_macros.svh =====
// Assertion macros used by the triangle hit test controller.
`ifndef TRIANGLE_LIST_HIT_TEST_MACROS_SVH
`define TRIANGLE_LIST_HIT_TEST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tlht_pkg.sv =====
// Shared constants, types and command/status structs of the triangle hit tester.
`default_nettype none
package tlht_pkg;
   localparam int MAX_TRIANGLES = 256;
   localparam int COORD_BITS    = 16;
   localparam int IDX_BITS      = $clog2(MAX_TRIANGLES);
   localparam int CNT_BITS      = 9;
   localparam int SLOT_BITS     = 8;
   localparam int CORNER_BITS   = 2;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int CROSS_BITS    = PROD_BITS + 1;
   localparam int DOT_BITS      = 2 * CROSS_BITS;
   localparam int SUM_BITS      = DOT_BITS + 2;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [CORNER_BITS-1:0] CORNER_A = 2'd0;
   localparam logic [CORNER_BITS-1:0] CORNER_B = 2'd1;
   localparam logic [CORNER_BITS-1:0] CORNER_C = 2'd2;

   typedef logic [1:0] side_type;
   localparam side_type SIDE_BC = 2'd0;  // edge B-C, opposite vertex A
   localparam side_type SIDE_AC = 2'd1;  // edge A-C, opposite vertex B
   localparam side_type SIDE_AB = 2'd2;  // edge A-B, opposite vertex C

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } vert_type;

   typedef struct packed {
      logic                load_point;
      logic                wr_en;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_index;
      logic                issue;
      side_type            side;
      logic                first;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic pass;
   } stat_type;
endpackage
`default_nettype wire

// ===== src/tlht_datapath.sv =====
// Vertex store and the pipelined same-side edge test of the triangle hit tester.
`default_nettype none
module tlht_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tlht_pkg::cmd_type                     cmd,
   output tlht_pkg::stat_type                         stat,
   input  wire logic [tlht_pkg::SLOT_BITS-1:0]        req_slot,
   input  wire logic [tlht_pkg::CORNER_BITS-1:0]      req_corner,
   input  wire logic signed [tlht_pkg::COORD_BITS-1:0] req_coord_x,
   input  wire logic signed [tlht_pkg::COORD_BITS-1:0] req_coord_y,
   input  wire logic signed [tlht_pkg::COORD_BITS-1:0] req_coord_z
);
   localparam int DW = tlht_pkg::DIFF_BITS;
   localparam int PW = tlht_pkg::PROD_BITS;
   localparam int CW = tlht_pkg::CROSS_BITS;
   localparam int QW = tlht_pkg::DOT_BITS;
   localparam int SW = tlht_pkg::SUM_BITS;

   tlht_pkg::vert_type mem_a [tlht_pkg::MAX_TRIANGLES];
   tlht_pkg::vert_type mem_b [tlht_pkg::MAX_TRIANGLES];
   tlht_pkg::vert_type mem_c [tlht_pkg::MAX_TRIANGLES];
   tlht_pkg::vert_type va_ff, vb_ff, vc_ff, pt_ff, wr_vert;
   logic [tlht_pkg::IDX_BITS-1:0] wr_index;

   assign wr_vert  = '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
   assign wr_index = req_slot[tlht_pkg::IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_en && req_corner == tlht_pkg::CORNER_A) mem_a[wr_index] <= wr_vert;
      if (cmd.wr_en && req_corner == tlht_pkg::CORNER_B) mem_b[wr_index] <= wr_vert;
      if (cmd.wr_en && req_corner == tlht_pkg::CORNER_C) mem_c[wr_index] <= wr_vert;
      if (cmd.rd_en) begin
         va_ff <= mem_a[cmd.rd_index];
         vb_ff <= mem_b[cmd.rd_index];
         vc_ff <= mem_c[cmd.rd_index];
      end
      if (cmd.load_point) pt_ff <= wr_vert;
   end

   // Edge selection: U and V span the edge, W is the opposite vertex.
   tlht_pkg::vert_type u, v, w;
   always_comb begin
      unique case (cmd.side)
         tlht_pkg::SIDE_BC: begin u = vb_ff; v = vc_ff; w = va_ff; end
         tlht_pkg::SIDE_AC: begin u = va_ff; v = vc_ff; w = vb_ff; end
         tlht_pkg::SIDE_AB: begin u = va_ff; v = vb_ff; w = vc_ff; end
         default:           begin u = va_ff; v = vb_ff; w = vc_ff; end
      endcase
   end

   logic signed [DW-1:0] e_ff [3], dp_ff [3], dw_ff [3];
   logic signed [DW-1:0] e_in [3], dp_in [3], dw_in [3];
   logic signed [PW-1:0] pa_ff [3], pb_ff [3], wa_ff [3], wb_ff [3];
   logic signed [CW-1:0] c1_ff [3], c2_ff [3];
   logic signed [QW-1:0] q_ff [3];
   logic signed [SW-1:0] sum;
   logic [4:1] vld_ff;
   logic [4:1] first_ff, last_ff;
   logic       acc_ff, done_ff, acc_in;

   always_comb begin
      e_in[0]  = DW'(v.x) - DW'(u.x);
      e_in[1]  = DW'(v.y) - DW'(u.y);
      e_in[2]  = DW'(v.z) - DW'(u.z);
      dp_in[0] = DW'(pt_ff.x) - DW'(u.x);
      dp_in[1] = DW'(pt_ff.y) - DW'(u.y);
      dp_in[2] = DW'(pt_ff.z) - DW'(u.z);
      dw_in[0] = DW'(w.x) - DW'(u.x);
      dw_in[1] = DW'(w.y) - DW'(u.y);
      dw_in[2] = DW'(w.z) - DW'(u.z);
   end

   assign sum    = SW'(q_ff[0]) + SW'(q_ff[1]) + SW'(q_ff[2]);
   assign acc_in = first_ff[4] ? !sum[SW-1] : (acc_ff && !sum[SW-1]);

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         e_ff[k]  <= e_in[k];
         dp_ff[k] <= dp_in[k];
         dw_ff[k] <= dw_in[k];
         // Cross component k takes axes k+1 and k+2, modulo three.
         pa_ff[k] <= PW'(e_ff[(k + 1) % 3] * dp_ff[(k + 2) % 3]);
         pb_ff[k] <= PW'(e_ff[(k + 2) % 3] * dp_ff[(k + 1) % 3]);
         wa_ff[k] <= PW'(e_ff[(k + 1) % 3] * dw_ff[(k + 2) % 3]);
         wb_ff[k] <= PW'(e_ff[(k + 2) % 3] * dw_ff[(k + 1) % 3]);
         c1_ff[k] <= CW'(pa_ff[k]) - CW'(pb_ff[k]);
         c2_ff[k] <= CW'(wa_ff[k]) - CW'(wb_ff[k]);
         q_ff[k]  <= QW'(c1_ff[k] * c2_ff[k]);
      end
      first_ff <= {first_ff[3:1], cmd.first};
      last_ff  <= {last_ff[3:1], cmd.last};
      if (vld_ff[4]) acc_ff <= acc_in;
      if (reset) begin
         vld_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         vld_ff  <= {vld_ff[3:1], cmd.issue};
         done_ff <= vld_ff[4] && last_ff[4];
      end
   end

   assign stat.done = done_ff;
   assign stat.pass = acc_ff;
endmodule
`default_nettype wire

// ===== src/tlht_control.sv =====
// Controller of the triangle hit tester: handshakes, count register and scan sequencing.
`default_nettype none
`include "triangle_list_hit_test_macros.svh"
module tlht_control (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_mode,
   input  wire logic [tlht_pkg::SLOT_BITS-1:0]      req_slot,
   input  wire logic [tlht_pkg::CORNER_BITS-1:0]    req_corner,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_hit,
   output logic [tlht_pkg::SLOT_BITS-1:0]           rsp_hit_index,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tlht_pkg::CNT_BITS-1:0]       csr_triangle_count,
   output tlht_pkg::cmd_type                        cmd,
   input  wire tlht_pkg::stat_type                  stat
);
   typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_ISSUE, ST_WAIT, ST_FINISH} state_type;

   localparam logic [tlht_pkg::CNT_BITS-1:0] MAX_COUNT =
      tlht_pkg::CNT_BITS'(tlht_pkg::MAX_TRIANGLES);

   state_type                      state_ff;
   logic [tlht_pkg::CNT_BITS-1:0]  count_ff, limit_ff, next_index;
   logic [tlht_pkg::IDX_BITS-1:0]  index_ff;
   tlht_pkg::side_type             side_ff;
   logic                           hit_ff, rsp_valid_ff, rsp_hit_ff;
   logic [tlht_pkg::SLOT_BITS-1:0] rsp_index_ff;
   logic                           req_take, rsp_free;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign next_index = tlht_pkg::CNT_BITS'(index_ff) + 1'b1;

   always_comb begin
      cmd            = '0;
      cmd.load_point = req_take && req_mode == tlht_pkg::MODE_QUERY;
      cmd.wr_en      = req_take && req_mode == tlht_pkg::MODE_LOAD
                       && req_corner <= tlht_pkg::CORNER_C
                       && tlht_pkg::CNT_BITS'(req_slot) < MAX_COUNT;
      cmd.rd_en      = (state_ff == ST_READ);
      cmd.rd_index   = index_ff;
      cmd.issue      = (state_ff == ST_ISSUE);
      cmd.side       = side_ff;
      cmd.first      = (side_ff == tlht_pkg::SIDE_BC);
      cmd.last       = (side_ff == tlht_pkg::SIDE_AB);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= '0;
         index_ff     <= '0;
         side_ff      <= tlht_pkg::SIDE_BC;
         hit_ff       <= 1'b0;
         rsp_hit_ff   <= 1'b0;
         rsp_index_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) count_ff <= csr_triangle_count;
         // In the finish state the output register is refilled instead.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FINISH) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load_point) begin
                  limit_ff <= (count_ff > MAX_COUNT) ? MAX_COUNT : count_ff;
                  index_ff <= '0;
                  hit_ff   <= 1'b0;
                  state_ff <= (count_ff == '0) ? ST_FINISH : ST_READ;
               end
            end
            ST_READ: begin
               side_ff  <= tlht_pkg::SIDE_BC;
               state_ff <= ST_ISSUE;
            end
            ST_ISSUE: begin
               if (side_ff == tlht_pkg::SIDE_AB) begin
                  state_ff <= ST_WAIT;
               end else begin
                  side_ff <= side_ff + 2'd1;
               end
            end
            ST_WAIT: begin
               if (stat.done) begin
                  if (stat.pass) begin
                     hit_ff   <= 1'b1;
                     state_ff <= ST_FINISH;
                  end else if (next_index == limit_ff) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     index_ff <= next_index[tlht_pkg::IDX_BITS-1:0];
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= hit_ff;
                  rsp_index_ff <= hit_ff ? tlht_pkg::SLOT_BITS'(index_ff) : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_index = rsp_index_ff;

   `TLHT_ASSERT_NOW(a_done_in_wait, clock, reset, stat.done, state_ff == ST_WAIT, "edge result outside wait")
   `TLHT_ASSERT_NOW(a_index_in_range, clock, reset, state_ff == ST_READ, tlht_pkg::CNT_BITS'(index_ff) < limit_ff, "scan index past count")
   `TLHT_ASSERT_NEXT(a_query_starts, clock, reset, cmd.load_point, state_ff != ST_IDLE, "query item did not start a scan")
endmodule
`default_nettype wire

// ===== src/triangle_list_hit_test.sv =====
// Top level of the triangle hit tester: controller plus datapath.
//
// Usage: the req_ channel takes items. mode 0 loads one vertex (slot, corner,
// coordinates) into the vertex store and gives no result; mode 1 queries a
// point and gives exactly one rsp_ item: hit and the lowest containing index.
// csr_triangle_count sets how many triangles a query scans (above 256 means
// 256); write it only while the block is idle. csr_ready is always high.
// Loads are taken back to back while idle. A query scans each triangle in turn
// (a store read, an issue for each of its edges, then the five-stage edge test pipeline
// drains) and takes no new item until it is done; the scan stops at the first
// hit. req_ready is low for the scan.
// A query with count zero answers with no hit without scanning.
// Reset clears the count and control state; the vertex store is not cleared,
// and a query must only scan vertices that were loaded.
// If the receiver stalls, the result waits in the output register; loads are
// still taken, and a following query scans but holds its result until the
// output register frees.
`default_nettype none
module triangle_list_hit_test (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_mode,
   input  wire logic [tlht_pkg::SLOT_BITS-1:0]         req_slot,
   input  wire logic [tlht_pkg::CORNER_BITS-1:0]       req_corner,
   input  wire logic signed [tlht_pkg::COORD_BITS-1:0] req_coord_x,
   input  wire logic signed [tlht_pkg::COORD_BITS-1:0] req_coord_y,
   input  wire logic signed [tlht_pkg::COORD_BITS-1:0] req_coord_z,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_hit,
   output logic [tlht_pkg::SLOT_BITS-1:0]              rsp_hit_index,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [tlht_pkg::CNT_BITS-1:0]          csr_triangle_count
);
   tlht_pkg::cmd_type  cmd;
   tlht_pkg::stat_type stat;

   tlht_control u_control (
      .clock, .reset,
      .req_valid, .req_ready, .req_mode, .req_slot, .req_corner,
      .rsp_valid, .rsp_ready, .rsp_hit, .rsp_hit_index,
      .csr_valid, .csr_ready, .csr_triangle_count,
      .cmd, .stat
   );

   tlht_datapath u_datapath (
      .clock, .reset, .cmd, .stat,
      .req_slot, .req_corner, .req_coord_x, .req_coord_y, .req_coord_z
   );
endmodule
`default_nettype wire
